@@ rtl/nibble_heap_allocation_map_top_macros.svh @@
// Assertion macros for the nibble heap allocation map.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef NIBBLE_HEAP_ALLOCATION_MAP_TOP_MACROS_SVH
`define NIBBLE_HEAP_ALLOCATION_MAP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define NHAM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
`define NHAM_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) pre |=> post) \
      else $error(msg);
`else
`define NHAM_ASSERT(lbl, prop, msg)
`define NHAM_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ rtl/nham_pkg.sv @@
// Shared sizes, codes and types of the nibble heap allocation map.
// No dependencies; imported by nham_map and nibble_heap_allocation_map_top.
package nham_pkg;

   localparam int HEAP_BYTES  = 4096;
   localparam int OWNER_COUNT = 8;

   localparam int MAP_BYTES = (HEAP_BYTES + 1) / 2;
   localparam int OFF_W     = $clog2(HEAP_BYTES);
   localparam int IDX_W     = OFF_W - 1;
   localparam int LEN_W     = $clog2(HEAP_BYTES + 1);
   localparam int OWN_W     = $clog2(OWNER_COUNT);
   localparam int SUM_W     = ((LEN_W > 13) ? LEN_W : 13) + 1;
   localparam int HL_W      = ((LEN_W > 16) ? LEN_W : 16) + 1;

   localparam logic [3:0] ENT_FREE = 4'h0;
   localparam logic [3:0] ENT_CONT = 4'hF;

   localparam logic [1:0] OP_MARK  = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_ALL   = 2'd2;
   localparam logic [1:0] OP_QUERY = 2'd3;

   localparam logic [1:0] STS_DONE    = 2'd0;
   localparam logic [1:0] STS_RANGE   = 2'd1;
   localparam logic [1:0] STS_NOCHUNK = 2'd2;

   localparam logic CSR_HEAP_BASE   = 1'b0;
   localparam logic CSR_HEAP_LENGTH = 1'b1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] address;
      logic [12:0] length;
      logic [3:0]  owner;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] chunk_start;
      logic [12:0] chunk_size;
      logic [3:0]  chunk_owner;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic             write;
      logic [OFF_W-1:0] off;
      logic [3:0]       wdata;
   } map_req_type;

   typedef struct packed {
      logic       ready;
      logic       hit;
      logic [3:0] rdata;
   } map_rsp_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_DEC,
      FSM_DEC2,
      FSM_MARK,
      FSM_FIND,
      FSM_RUN,
      FSM_SCAN,
      FSM_RESULT
   } state_type;

endpackage

@@ rtl/nham_map.sv @@
// Allocation map storage: byte-wide synchronous RAM, one-byte line buffer, clear sweep.
// Depends on nham_pkg and nibble_heap_allocation_map_top_macros.svh.
`include "nibble_heap_allocation_map_top_macros.svh"

module nham_map import nham_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  map_req_type map_req,
   output map_rsp_type map_rsp
);

   localparam logic [7:0]       NIB_HI_MASK = 8'hF0;
   localparam logic [7:0]       NIB_LO_MASK = 8'h0F;
   localparam logic [IDX_W-1:0] CLR_LAST    = IDX_W'(MAP_BYTES - 1);

   logic [7:0] map_mem [MAP_BYTES];
   logic [7:0] rd_data_ff;

   logic [7:0]       line_ff, line_in;
   logic [IDX_W-1:0] tag_ff, tag_in;
   logic             line_vld_ff, line_vld_in;
   logic             dirty_ff, dirty_in;
   logic             fill_ff, fill_in;
   logic             clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;

   logic [7:0]       cur_byte;
   logic [7:0]       merged;
   logic [IDX_W-1:0] idx;
   logic             hit;
   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]       mem_wdata;

   // the freshly read byte stands in for the line during the fill cycle
   assign cur_byte = fill_ff ? rd_data_ff : line_ff;
   assign idx      = map_req.off[OFF_W-1:1];
   assign hit      = !clr_busy_ff && line_vld_ff && (tag_ff == idx);
   assign merged   = map_req.off[0] ? ((cur_byte & NIB_HI_MASK) | {4'h0, map_req.wdata})
                                    : ({map_req.wdata, 4'h0} | (cur_byte & NIB_LO_MASK));

   assign map_rsp.ready = !clr_busy_ff;
   assign map_rsp.hit   = hit;
   assign map_rsp.rdata = map_req.off[0] ? cur_byte[3:0] : cur_byte[7:4];

   always_comb begin
      line_in     = cur_byte;
      tag_in      = tag_ff;
      line_vld_in = line_vld_ff;
      dirty_in    = dirty_ff;
      fill_in     = 1'b0;
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      mem_we      = 1'b0;
      mem_waddr   = tag_ff;
      mem_wdata   = cur_byte;
      mem_re      = 1'b0;
      mem_raddr   = idx;
      if (clr_busy_ff) begin
         mem_we     = 1'b1;
         mem_waddr  = clr_idx_ff;
         mem_wdata  = 8'h00;
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == CLR_LAST) begin
            clr_busy_in = 1'b0;
         end
      end else if (map_req.valid) begin
         if (hit) begin
            if (map_req.write) begin
               line_in  = merged;
               dirty_in = 1'b1;
            end
         end else begin
            // evict the line if modified, fetch the new byte in the same cycle
            mem_we      = dirty_ff;
            mem_re      = 1'b1;
            tag_in      = idx;
            line_vld_in = 1'b1;
            fill_in     = 1'b1;
            dirty_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= map_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_vld_ff <= 1'b0;
         dirty_ff    <= 1'b0;
         fill_ff     <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         line_vld_ff <= line_vld_in;
         dirty_ff    <= dirty_in;
         fill_ff     <= fill_in;
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
      tag_ff  <= tag_in;
   end

   `NHAM_ASSERT(a_wr_rd_apart, (mem_we && mem_re) |-> (mem_waddr != mem_raddr), "evict and fetch hit one byte")
   `NHAM_ASSERT(a_clr_full, $fell(clr_busy_ff) |-> ($past(clr_idx_ff) == CLR_LAST), "clear sweep cut short")
   `NHAM_ASSERT(a_dirty_vld, dirty_ff |-> line_vld_ff, "modified line without a valid tag")

endmodule

@@ rtl/nibble_heap_allocation_map_top.sv @@
// Top level of the nibble heap allocation map: request sequencer, owner records, CSRs.
// Depends on nham_pkg, nham_map and nibble_heap_allocation_map_top_macros.svh.
//
//   channel   direction  handshake              beat
//   req_      in         req_valid / req_stall  req_type: opcode, address, length, owner
//   rsp_      out        rsp_valid / rsp_stall  rsp_type: status, chunk_start/size/owner
//   csr_      in         csr_valid / csr_ready  csr_index (0 heap_base, 1 heap_length)
//
// One operation at a time. An operation passes through decode and result handling and
// visits map entries one at a time, and it waits for a line fill each time the walk
// enters a new map byte (the map RAM serves one byte per fetch through a one-byte line).
// After reset the map is swept to zero, one byte per cycle, with req_stall high; CSR
// writes are taken meanwhile. A finished beat waits in the rsp register, and the next
// request is taken while it waits.
`include "nibble_heap_allocation_map_top_macros.svh"

module nibble_heap_allocation_map_top import nham_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration and values derived from it
   logic [15:0]     base_ff, base_in;
   logic [12:0]     hlen_ff, hlen_in;
   logic [LEN_W-1:0] len_c, len_ff;
   logic [HL_W-1:0]  heap_last_ff;

   // sequencer
   state_type state_ff, state_in;

   logic [1:0]  op_ff, op_in;
   logic [15:0] addr_ff, addr_in;
   logic [12:0] length_ff, length_in;
   logic [3:0]  owner_ff, owner_in;

   logic [OFF_W-1:0] off_ff, off_in;
   logic             inh_ff, inh_in;
   logic [HL_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [12:0]      nlm1_ff, nlm1_in;
   logic [LEN_W-1:0] mark_last_ff, mark_last_in;
   logic [OFF_W-1:0] lo_off_ff, lo_off_in, hi_off_ff, hi_off_in;

   logic [LEN_W-1:0] p_ff, p_in;
   logic [OFF_W-1:0] s_ff, s_in;
   logic             first_ff, first_in;
   logic             clr_ff, clr_in;
   logic             fa_ff, fa_in;

   logic [1:0]  res_status_ff, res_status_in;
   logic [15:0] res_start_ff, res_start_in;
   logic [12:0] res_size_ff, res_size_in;
   logic [3:0]  res_owner_ff, res_owner_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [15:0]            first_tab_ff [OWNER_COUNT];
   logic [15:0]            first_tab_in [OWNER_COUNT];
   logic [15:0]            last_tab_ff  [OWNER_COUNT];
   logic [15:0]            last_tab_in  [OWNER_COUNT];
   logic [OWNER_COUNT-1:0] rec_ff, rec_in;

   map_req_type map_req;
   map_rsp_type map_rsp;

   // working terms
   logic             acc;
   logic             own_ok;
   logic [OWN_W-1:0] own_idx;
   logic [15:0]      off16;
   logic             rec;
   logic [HL_W-1:0]  raw_lo, raw_hi;
   logic [SUM_W-1:0] mark_last;
   logic             range_bad;
   logic             lo_gt_hi;
   logic             hit;
   logic [3:0]       ent;
   logic             run_stop_len, run_part, run_step, run_done;
   logic             find_cont, find_fail, find_back, find_ok;
   logic             scan_end, scan_match;
   logic             mark_done;
   logic             rsp_free, rsp_load;

   nham_map u_map (
      .clock   (clock),
      .reset   (reset),
      .map_req (map_req),
      .map_rsp (map_rsp)
   );

   // ---------------------------------------------------------------- CSRs
   assign csr_ready = 1'b1;

   always_comb begin
      base_in = base_ff;
      hlen_in = hlen_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HEAP_BASE:   base_in = csr_wdata;
            CSR_HEAP_LENGTH: hlen_in = csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // clip the length to the map size; keep the last heap address at hand
   assign len_c = (32'(hlen_ff) > HEAP_BYTES) ? LEN_W'(HEAP_BYTES) : LEN_W'(hlen_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         hlen_ff <= 13'(HEAP_BYTES);
      end else begin
         base_ff <= base_in;
         hlen_ff <= hlen_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_c;
      heap_last_ff <= HL_W'(base_ff) + HL_W'(len_c) - HL_W'(1);
   end

   // ---------------------------------------------------------------- terms
   assign acc      = req_valid && !req_stall;
   assign own_ok   = (owner_ff != ENT_FREE) && (owner_ff != ENT_CONT)
                     && (32'(owner_ff) < OWNER_COUNT);
   assign own_idx  = owner_ff[OWN_W-1:0];
   assign off16    = addr_ff - base_ff;
   assign rec      = rec_ff[own_idx];
   assign raw_lo   = rec ? HL_W'(first_tab_ff[own_idx]) : HL_W'(base_ff);
   assign raw_hi   = rec ? HL_W'(last_tab_ff[own_idx]) : heap_last_ff;

   assign mark_last = SUM_W'(off_ff) + SUM_W'(nlm1_ff);
   assign range_bad = mark_last >= SUM_W'(len_ff);
   assign lo_gt_hi  = lo_ff > hi_ff;

   assign hit = map_rsp.hit;
   assign ent = map_rsp.rdata;

   // a run goes on while entries read as continuation and stay inside the heap
   assign run_stop_len = !first_ff && (p_ff >= len_ff);
   assign run_part     = first_ff || (ent == ENT_CONT);
   assign run_step     = !run_stop_len && hit && run_part;
   assign run_done     = run_stop_len || (hit && !run_part);

   assign find_cont = ent == ENT_CONT;
   assign find_fail = hit && find_cont && (p_ff == '0);
   assign find_back = hit && find_cont && (p_ff != '0);
   assign find_ok   = hit && !find_cont;

   assign scan_end   = p_ff > LEN_W'(hi_off_ff);
   assign scan_match = !scan_end && hit && (ent == owner_ff);

   assign mark_done = hit && (p_ff == mark_last_ff);

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = (state_ff == FSM_RESULT) && rsp_free;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (acc) state_in = FSM_DEC;
         end
         FSM_DEC: state_in = FSM_DEC2;
         FSM_DEC2: begin
            unique case (op_ff) inside
               OP_MARK: begin
                  state_in = (!inh_ff || range_bad || !own_ok) ? FSM_RESULT : FSM_MARK;
               end
               OP_FREE, OP_QUERY: begin
                  state_in = !inh_ff ? FSM_RESULT : FSM_FIND;
               end
               default: begin
                  state_in = (!own_ok || (len_ff == '0) || lo_gt_hi) ? FSM_RESULT : FSM_FIND;
               end
            endcase
         end
         FSM_MARK: begin
            if (mark_done) state_in = FSM_RESULT;
         end
         FSM_FIND: begin
            if (find_fail) begin
               state_in = fa_ff ? FSM_SCAN : FSM_RESULT;
            end else if (find_ok) begin
               if (fa_ff) state_in = FSM_SCAN;
               else state_in = (ent == ENT_FREE) ? FSM_RESULT : FSM_RUN;
            end
         end
         FSM_RUN: begin
            if (run_done) state_in = fa_ff ? FSM_SCAN : FSM_RESULT;
         end
         FSM_SCAN: begin
            if (scan_end) state_in = FSM_RESULT;
            else if (scan_match) state_in = FSM_RUN;
         end
         FSM_RESULT: begin
            if (rsp_free) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      map_req.valid = 1'b0;
      map_req.write = 1'b0;
      map_req.off   = OFF_W'(p_ff);
      map_req.wdata = ENT_FREE;
      req_stall     = (state_ff != FSM_IDLE) || !map_rsp.ready || csr_valid;
      unique case (state_ff)
         FSM_MARK: begin
            map_req.valid = 1'b1;
            map_req.write = 1'b1;
            map_req.wdata = first_ff ? owner_ff : ENT_CONT;
         end
         FSM_FIND: map_req.valid = 1'b1;
         FSM_RUN: begin
            map_req.valid = !run_stop_len;
            map_req.write = clr_ff && run_part;
         end
         FSM_SCAN: map_req.valid = !scan_end;
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- datapath
   always_comb begin
      op_in         = op_ff;
      addr_in       = addr_ff;
      length_in     = length_ff;
      owner_in      = owner_ff;
      off_in        = off_ff;
      inh_in        = inh_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      nlm1_in       = nlm1_ff;
      mark_last_in  = mark_last_ff;
      lo_off_in     = lo_off_ff;
      hi_off_in     = hi_off_ff;
      p_in          = p_ff;
      s_in          = s_ff;
      first_in      = first_ff;
      clr_in        = clr_ff;
      fa_in         = fa_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_size_in   = res_size_ff;
      res_owner_in  = res_owner_ff;
      first_tab_in  = first_tab_ff;
      last_tab_in   = last_tab_ff;
      rec_in        = rec_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_load || (rsp_valid_ff && rsp_stall);

      unique case (state_ff)
         FSM_IDLE: begin
            if (acc) begin
               op_in         = req_data.opcode;
               addr_in       = req_data.address;
               length_in     = req_data.length;
               owner_in      = req_data.owner;
               fa_in         = 1'b0;
               clr_in        = 1'b0;
               res_status_in = STS_DONE;
               res_start_in  = '0;
               res_size_in   = '0;
               res_owner_in  = '0;
            end
         end
         FSM_DEC: begin
            off_in  = OFF_W'(off16);
            inh_in  = (addr_ff >= base_ff) && (32'(off16) < 32'(len_ff));
            nlm1_in = (length_ff == '0) ? '0 : length_ff - 13'd1;
            lo_in   = (raw_lo < HL_W'(base_ff)) ? HL_W'(base_ff) : raw_lo;
            hi_in   = (raw_hi > heap_last_ff) ? heap_last_ff : raw_hi;
         end
         FSM_DEC2: begin
            mark_last_in = LEN_W'(mark_last);
            lo_off_in    = OFF_W'(lo_ff - HL_W'(base_ff));
            hi_off_in    = OFF_W'(hi_ff - HL_W'(base_ff));
            first_in     = 1'b1;
            unique case (op_ff) inside
               OP_MARK: begin
                  p_in = LEN_W'(off_ff);
                  if (!inh_ff || range_bad) begin
                     res_status_in = STS_RANGE;
                  end else if (!own_ok) begin
                     res_status_in = STS_NOCHUNK;
                  end else begin
                     res_start_in = addr_ff;
                     res_size_in  = nlm1_ff + 13'd1;
                     res_owner_in = owner_ff;
                     // widen the owner's recorded span of chunk starts
                     if (!rec || (addr_ff < first_tab_ff[own_idx])) begin
                        first_tab_in[own_idx] = addr_ff;
                     end
                     if (!rec || (addr_ff > last_tab_ff[own_idx])) begin
                        last_tab_in[own_idx] = addr_ff;
                     end
                     rec_in[own_idx] = 1'b1;
                  end
               end
               OP_FREE, OP_QUERY: begin
                  p_in = LEN_W'(off_ff);
                  if (!inh_ff) res_status_in = STS_RANGE;
               end
               default: begin
                  p_in  = LEN_W'(lo_ff - HL_W'(base_ff));
                  fa_in = 1'b1;
                  if (!own_ok) res_status_in = STS_NOCHUNK;
               end
            endcase
         end
         FSM_MARK: begin
            if (hit) begin
               p_in     = p_ff + 1'b1;
               first_in = 1'b0;
            end
         end
         FSM_FIND: begin
            // step back over continuation entries to the chunk start
            if (find_back) begin
               p_in = p_ff - 1'b1;
            end else if (find_fail) begin
               if (fa_ff) p_in = LEN_W'(lo_off_ff);
               else res_status_in = STS_NOCHUNK;
            end else if (find_ok) begin
               s_in     = OFF_W'(p_ff);
               first_in = 1'b1;
               if (!fa_ff) begin
                  res_start_in = base_ff + 16'(p_ff);
                  if (ent == ENT_FREE) begin
                     res_status_in = (op_ff == OP_FREE) ? STS_NOCHUNK : STS_DONE;
                  end else begin
                     res_owner_in = ent;
                     clr_in       = (op_ff == OP_FREE) && (ent == owner_ff);
                     if ((op_ff == OP_FREE) && (ent != owner_ff)) begin
                        res_status_in = STS_NOCHUNK;
                     end
                  end
               end
            end
         end
         FSM_RUN: begin
            if (run_step) begin
               p_in     = p_ff + 1'b1;
               first_in = 1'b0;
            end
            if (run_done && !fa_ff) begin
               res_size_in = 13'(p_ff - LEN_W'(s_ff));
            end
         end
         FSM_SCAN: begin
            if (scan_match) begin
               first_in = 1'b1;
               clr_in   = 1'b1;
            end else if (hit && !scan_end) begin
               p_in = p_ff + 1'b1;
            end
         end
         FSM_RESULT: begin
            if (rsp_load) begin
               rsp_data_in.status      = res_status_ff;
               rsp_data_in.chunk_start = res_start_ff;
               rsp_data_in.chunk_size  = res_size_ff;
               rsp_data_in.chunk_owner = res_owner_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
         rec_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rec_ff       <= rec_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      length_ff     <= length_in;
      owner_ff      <= owner_in;
      off_ff        <= off_in;
      inh_ff        <= inh_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      nlm1_ff       <= nlm1_in;
      mark_last_ff  <= mark_last_in;
      lo_off_ff     <= lo_off_in;
      hi_off_ff     <= hi_off_in;
      p_ff          <= p_in;
      s_ff          <= s_in;
      first_ff      <= first_in;
      clr_ff        <= clr_in;
      fa_ff         <= fa_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_size_ff   <= res_size_in;
      res_owner_ff  <= res_owner_in;
      rsp_data_ff   <= rsp_data_in;
      first_tab_ff  <= first_tab_in;
      last_tab_ff   <= last_tab_in;
   end

   `NHAM_ASSERT_NEXT(a_acc_dec, acc, (state_ff == FSM_DEC), "accepted beat did not enter decode")
   `NHAM_ASSERT(a_mark_bound, (state_ff == FSM_MARK) |-> (p_ff <= mark_last_ff), "mark walk ran past chunk end")
   `NHAM_ASSERT(a_run_bound, (state_ff == FSM_RUN) |-> (p_ff <= len_ff), "run walk ran past heap end")

endmodule

@@ test/tb.sv @@
// Self-checking testbench for nibble_heap_allocation_map_top: random and directed
// mark/free/free-all/query beats checked against an in-bench model of the allocation map.
// Depends on nham_pkg and the RTL of the block; stands alone otherwise.
module tb;
   import nham_pkg::*;

   localparam int unsigned IDLE_LIMIT     = 100000;
   localparam int unsigned HOLDOFF_CYCLES = 400;
   localparam int unsigned MAX_PRINTED    = 100;
   localparam int unsigned DRAIN_CYCLES   = 64;

   // remembered chunks, so that frees and queries hit live allocations
   typedef struct {
      logic [15:0] addr;
      int unsigned size;
      logic [3:0]  owner;
   } chunk_note;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_HEAP_BASE;
   logic [15:0] csr_wdata = '0;

   // model of the block: one entry per heap byte, owner records, registers
   logic [3:0]  heap_entry [0:HEAP_BYTES-1];
   logic [15:0] owner_first [0:OWNER_COUNT-1];
   logic [15:0] owner_last [0:OWNER_COUNT-1];
   bit          owner_seen [0:OWNER_COUNT-1];
   logic [15:0] heap_origin;
   logic [12:0] heap_span_reg;

   req_type     queued_requests[$];
   rsp_type     pending_results[$];
   chunk_note   recent_chunks[$];

   int unsigned mismatch_count = 0;
   int unsigned send_wait = 0;
   int unsigned recv_wait = 0;
   int unsigned silent_cycles = 0;
   int unsigned holdoff_left = 0;
   bit          holdoff_request = 1'b0;
   bit          steady_flow = 1'b0;

   nibble_heap_allocation_map_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED) $display("MISMATCH: %s", msg);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Map model
   // ---------------------------------------------------------------------

   // lengths above the map size act as the map size
   function automatic int unsigned usable_span();
      return (heap_span_reg > HEAP_BYTES) ? HEAP_BYTES : heap_span_reg;
   endfunction

   // translate an absolute address into a heap offset; 0 when outside the heap
   function automatic bit locate(input logic [15:0] addr, output int unsigned off);
      int unsigned a;
      a = addr;
      off = 0;
      if (a < heap_origin || a - heap_origin >= usable_span()) return 1'b0;
      off = a - heap_origin;
      return 1'b1;
   endfunction

   // walk back over continuation entries; fails when offset 0 is still a continuation entry
   function automatic bit chunk_head(input int unsigned off, output int unsigned head);
      int unsigned p;
      p = off;
      while (p > 0 && heap_entry[p] == ENT_CONT) p--;
      head = p;
      return heap_entry[p] != ENT_CONT;
   endfunction

   // first offset past the chunk that starts at head, clipped to the heap
   function automatic int unsigned run_stop(input int unsigned head);
      int unsigned p;
      p = head + 1;
      while (p < usable_span() && heap_entry[p] == ENT_CONT) p++;
      return p;
   endfunction

   function automatic int unsigned release_run(input int unsigned head);
      int unsigned stop;
      stop = run_stop(head);
      for (int unsigned p = head; p < stop; p++) heap_entry[p] = ENT_FREE;
      return stop;
   endfunction

   function automatic bit owner_valid(input logic [3:0] owner);
      return owner != ENT_FREE && owner != ENT_CONT && owner < OWNER_COUNT;
   endfunction

   // apply one request beat to the map and return the result beat it causes
   function automatic rsp_type map_operation(input req_type r);
      rsp_type     res;
      int unsigned span, off, head, n, lo, hi, p;
      logic [3:0]  ent;
      res = '0;
      span = usable_span();
      if (r.opcode == OP_MARK) begin
         n = (r.length != 0) ? r.length : 1;
         if (!locate(r.address, off) || off + n > span) begin
            res.status = STS_RANGE;
         end else if (!owner_valid(r.owner)) begin
            res.status = STS_NOCHUNK;
         end else begin
            // overlaps are not checked: overwrite whatever is there
            heap_entry[off] = r.owner;
            for (p = 1; p < n; p++) heap_entry[off + p] = ENT_CONT;
            if (!owner_seen[r.owner] || r.address < owner_first[r.owner])
               owner_first[r.owner] = r.address;
            if (!owner_seen[r.owner] || r.address > owner_last[r.owner])
               owner_last[r.owner] = r.address;
            owner_seen[r.owner] = 1'b1;
            res.chunk_start = r.address;
            res.chunk_size  = n;
            res.chunk_owner = r.owner;
         end
      end else if (r.opcode == OP_ALL) begin
         if (!owner_valid(r.owner)) begin
            res.status = STS_NOCHUNK;
         end else if (span != 0) begin
            // walk from first to last recorded start, whole heap if none recorded
            lo = owner_seen[r.owner] ? owner_first[r.owner] : heap_origin;
            hi = owner_seen[r.owner] ? owner_last[r.owner] : heap_origin + span - 1;
            if (lo < heap_origin) lo = heap_origin;
            if (hi > heap_origin + span - 1) hi = heap_origin + span - 1;
            if (lo <= hi) begin
               lo = lo - heap_origin;
               hi = hi - heap_origin;
               p = chunk_head(lo, head) ? head : lo;
               while (p <= hi) begin
                  if (heap_entry[p] == r.owner) p = release_run(p);
                  else p++;
               end
            end
         end
      end else begin
         // free or query: report the chunk as it was before the operation
         if (!locate(r.address, off)) begin
            res.status = STS_RANGE;
         end else if (!chunk_head(off, head)) begin
            res.status = STS_NOCHUNK;
         end else begin
            ent = heap_entry[head];
            res.chunk_start = heap_origin + head;
            if (ent == ENT_FREE) begin
               res.status = (r.opcode == OP_FREE) ? STS_NOCHUNK : STS_DONE;
            end else begin
               res.chunk_size  = run_stop(head) - head;
               res.chunk_owner = ent;
               if (r.opcode == OP_FREE) begin
                  if (ent == r.owner) void'(release_run(head));
                  else res.status = STS_NOCHUNK;
               end
            end
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic int unsigned draw_wait();
      return steady_flow ? 0 : $urandom_range(0, 17);
   endfunction

   task automatic push_op(input logic [1:0] opcode, input logic [15:0] address,
                          input logic [12:0] length, input logic [3:0] owner);
      req_type op;
      op.opcode  = opcode;
      op.address = address;
      op.length  = length;
      op.owner   = owner;
      queued_requests.push_back(op);
   endtask

   // mostly well-formed traffic aimed at live chunks, the rest noise
   function automatic req_type random_op();
      req_type     op;
      chunk_note   note;
      int unsigned span, off, pick, w;
      op = '0;
      span = usable_span();
      w = $urandom_range(0, 99);
      if (w < 35) begin
         off = $urandom_range(0, span - 1);
         op.opcode  = OP_MARK;
         op.address = heap_origin + off;
         if ($urandom_range(0, 19) == 0) op.owner = $urandom_range(0, 15);
         else op.owner = $urandom_range(1, OWNER_COUNT - 1);
         // keep most chunks small: a mark costs time per byte
         pick = $urandom_range(0, 99);
         if (pick < 80) op.length = $urandom_range(0, 12);
         else if (pick < 97) op.length = $urandom_range(13, 200);
         else op.length = $urandom_range(0, HEAP_BYTES);
         if (op.length > span - off && $urandom_range(0, 9) != 0) op.length = span - off;
         note.addr  = op.address;
         note.size  = (op.length == 0) ? 1 : op.length;
         note.owner = op.owner;
         recent_chunks.push_back(note);
         if (recent_chunks.size() > 24) void'(recent_chunks.pop_front());
      end else if (w < 85) begin
         op.opcode = (w < 55) ? OP_FREE : OP_QUERY;
         op.length = $urandom_range(0, 8191);
         if (recent_chunks.size() != 0 && $urandom_range(0, 4) != 0) begin
            pick = $urandom_range(0, recent_chunks.size() - 1);
            note = recent_chunks[pick];
            op.address = note.addr + $urandom_range(0, note.size - 1);
            if ($urandom_range(0, 6) != 0) op.owner = note.owner;
            else op.owner = $urandom_range(0, 15);
            if (op.opcode == OP_FREE && op.owner == note.owner) recent_chunks.delete(pick);
         end else begin
            // straddle both heap edges
            op.address = heap_origin + $urandom_range(0, span + 3) - 2;
            op.owner   = $urandom_range(0, 15);
         end
      end else if (w < 85 + ((span > 512) ? 2 : 7)) begin
         // free-all walks a range, so keep it rare on large heaps
         op.opcode  = OP_ALL;
         op.address = $urandom_range(0, 65535);
         op.length  = $urandom_range(0, 8191);
         if ($urandom_range(0, 7) != 0) op.owner = $urandom_range(1, OWNER_COUNT - 1);
         else op.owner = $urandom_range(0, 15);
      end else begin
         op.opcode  = $urandom_range(0, 3);
         op.address = $urandom_range(0, 65535);
         op.length  = $urandom_range(0, 8191);
         op.owner   = $urandom_range(0, 15);
      end
      return op;
   endfunction

   // hold until every queued beat went in and every result came back
   task automatic wait_idle();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_valid || pending_results.size() != 0);
   endtask

   task automatic csr_write(input logic idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_HEAP_BASE) heap_origin = value;
      else heap_span_reg = value[12:0];
   endtask

   // write both registers with the block idle, then line up on a falling edge
   task automatic configure(input logic [15:0] base, input logic [15:0] length);
      wait_idle();
      csr_write(CSR_HEAP_BASE, base);
      csr_write(CSR_HEAP_LENGTH, length);
      @(negedge clock);
      recent_chunks.delete();
   endtask

   task automatic run_phase(input logic [15:0] base, input logic [15:0] length,
                            input int count, input bit steady, input bit hold);
      configure(base, length);
      steady_flow = steady;
      repeat (count) queued_requests.push_back(random_op());
      // the receiver holds off while the sender keeps offering beats
      if (hold) holdoff_request = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Request driver: present queued beats, drawing a gap before each one
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            // beat accepted: predict its result now, in acceptance order
            pending_results.push_back(map_operation(req_data));
            next_valid = 1'b0;
            send_wait = draw_wait();
         end
         if (!next_valid) begin
            if (send_wait != 0) begin
               send_wait--;
            end else if (queued_requests.size() != 0) begin
               req_data <= queued_requests.pop_front();
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
      end
   end

   // Long receiver hold-off, counted here and seen by the monitor
   always @(posedge clock) begin
      if (reset) begin
         holdoff_left <= 0;
      end else if (holdoff_request) begin
         holdoff_left <= HOLDOFF_CYCLES;
         holdoff_request = 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: compare each accepted beat with the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               flag_mismatch($sformatf("result beat with nothing outstanding: %h", rsp_data));
            end else begin
               want = pending_results.pop_front();
               if (rsp_data !== want)
                  flag_mismatch($sformatf(
                     "status/start/size/owner got %0d/%h/%0d/%0d want %0d/%h/%0d/%0d",
                     rsp_data.status, rsp_data.chunk_start, rsp_data.chunk_size,
                     rsp_data.chunk_owner, want.status, want.chunk_start,
                     want.chunk_size, want.chunk_owner));
            end
            recv_wait = draw_wait();
         end else if (recv_wait != 0) begin
            recv_wait--;
         end
         rsp_stall <= (recv_wait != 0) || (holdoff_left != 0);
      end
   end

   // Watchdog: end the run when no channel moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         silent_cycles = 0;
      end else begin
         silent_cycles++;
         if (silent_cycles == IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      foreach (heap_entry[i]) heap_entry[i] = ENT_FREE;
      foreach (owner_seen[i]) begin
         owner_first[i] = '0;
         owner_last[i]  = '0;
         owner_seen[i]  = 1'b0;
      end
      heap_origin   = '0;
      heap_span_reg = 13'd4096;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: whole default heap at address 0
      configure(16'h0000, 16'd4096);
      push_op(OP_MARK, 16'd0, 13'd0, 4'd1);          // zero length marks one byte
      push_op(OP_MARK, 16'd1, 13'd5, 4'd2);
      push_op(OP_QUERY, 16'd3, 13'd0, 4'd0);         // byte inside a chunk
      push_op(OP_QUERY, 16'd100, 13'd0, 4'd0);       // free byte
      push_op(OP_FREE, 16'd3, 13'd0, 4'd1);          // wrong owner
      push_op(OP_FREE, 16'd2, 13'd0, 4'd2);
      push_op(OP_FREE, 16'd2, 13'd0, 4'd2);          // free of a free byte
      push_op(OP_MARK, 16'd10, 13'd4, 4'd0);         // refused owners
      push_op(OP_MARK, 16'd10, 13'd4, 4'd15);
      push_op(OP_MARK, 16'd10, 13'd4, 4'd8);
      push_op(OP_MARK, 16'd4095, 13'd1, 4'd7);       // last heap byte
      push_op(OP_MARK, 16'd4094, 13'd3, 4'd7);       // runs past the heap end
      push_op(OP_MARK, 16'hFFFF, 13'd1, 4'd7);       // outside the heap
      push_op(OP_QUERY, 16'hFFFF, 13'd0, 4'd7);
      push_op(OP_ALL, 16'd0, 13'd0, 4'd0);           // refused owners for free-all
      push_op(OP_ALL, 16'd0, 13'd0, 4'd15);
      push_op(OP_ALL, 16'd0, 13'd0, 4'd6);           // no record: whole heap walk
      push_op(OP_MARK, 16'd40, 13'd6, 4'd7);
      push_op(OP_MARK, 16'd42, 13'd2, 4'd5);         // overwrite inside another chunk
      push_op(OP_QUERY, 16'd45, 13'd0, 4'd0);
      push_op(OP_ALL, 16'd0, 13'd0, 4'd7);           // recorded range 40..4095
      push_op(OP_MARK, 16'd0, 13'd4096, 4'd3);       // whole heap in one chunk
      push_op(OP_MARK, 16'd0, 13'd8191, 4'd3);
      push_op(OP_QUERY, 16'd4095, 13'd0, 4'd0);
      push_op(OP_FREE, 16'd0, 13'd0, 4'd3);

      // Register extremes: one-byte heap at the top, heaps touching and
      // crossing the end of the address space, length above the map size
      run_phase(16'hFFFF, 16'd1, 40, 1'b0, 1'b0);
      run_phase(16'hF000, 16'd4096, 150, 1'b0, 1'b0);
      run_phase(16'hFF00, 16'd4096, 60, 1'b1, 1'b0);
      run_phase(16'h1234, 16'd8191, 60, 1'b0, 1'b0);

      // Random heaps, mostly small so that walks stay short
      for (int ph = 0; ph < 13; ph++) begin
         run_phase($urandom_range(0, 65535),
                   (ph % 4 == 3) ? $urandom_range(301, 1024) : $urandom_range(1, 300),
                   120, ph % 3 == 2, ph == 0);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
